>>> hdl/bubble_sort_buffer_macros.svh
// Assertion macros used by the bubble sort buffer sequencer.
`ifndef BUBBLE_SORT_BUFFER_MACROS_SVH
`define BUBBLE_SORT_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge out of reset.
`define BSB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bubble sort buffer: assertion failed");
// Checks that a condition is followed in the next cycle by a consequence.
`define BSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bubble sort buffer: assertion failed");
`else
`define BSB_ASSERT(label, prop)
`define BSB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/bsb_pkg.sv
// Package with the types and constants of the bubble sort buffer.
`timescale 1ns / 1ps
package bsb_pkg;

    // Width of one stored value and the default buffer depth.
    localparam int DATA_W      = 32;
    localparam int DEPTH_DEF   = 16;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FIRST,
        S_SWEEP,
        S_TAIL,
        S_OSTART,
        S_OUT
    } state_t;

    // Source of the value written into the buffer.
    typedef enum logic [1:0] {
        WSEL_IN,
        WSEL_LO,
        WSEL_CARRY
    } wsel_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic  mem_we;
        wsel_t wsel;
        logic  carry_load_mem;
        logic  carry_take_hi;
        logic  out_fire;
        logic  out_last;
        logic  out_ovf;
    } ctrl_t;

endpackage

>>> hdl/bsb_swap_unit.sv
// Shared signed compare-and-swap unit: orders two values into low and high.
`timescale 1ns / 1ps
module bsb_swap_unit
    import bsb_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic signed [DATA_W-1:0] lo,
    output logic signed [DATA_W-1:0] hi
);

    logic greater;

    // Swap only when the left value is strictly greater, so equal values stay.
    always_comb
    begin
        greater = (a > b);
        lo      = greater ? b : a;
        hi      = greater ? a : b;
    end

endmodule

>>> hdl/bsb_datapath.sv
// Buffer memory, bubbling carry register and result registers.
`timescale 1ns / 1ps
module bsb_datapath
    import bsb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_t                      ctrl,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    input  logic signed [DATA_W-1:0]   element,
    output logic                       valid,
    output logic signed [DATA_W-1:0]   sorted_value,
    output logic                       run_end,
    output logic                       overflowed
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] carry_reg;
    logic signed [DATA_W-1:0] carry_next;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic                     valid_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     run_end_reg;
    logic                     ovf_reg;

    // The carry holds the largest value seen so far in the current pass.
    bsb_swap_unit u_swap (
        .a  (carry_reg),
        .b  (rdata_reg),
        .lo (lo),
        .hi (hi)
    );

    // Write data selection.
    always_comb
    begin
        unique case (ctrl.wsel)
            WSEL_IN:    wdata = element;
            WSEL_LO:    wdata = lo;
            WSEL_CARRY: wdata = carry_reg;
            default:    wdata = element;
        endcase
    end

    // Buffer memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Carry register update.
    always_comb
    begin
        priority if (ctrl.carry_load_mem)
            carry_next = rdata_reg;
        else if (ctrl.carry_take_hi)
            carry_next = hi;
        else
            carry_next = carry_reg;
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.out_fire;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.out_fire)
        begin
            value_reg   <= rdata_reg;
            run_end_reg <= ctrl.out_last;
            ovf_reg     <= ctrl.out_ovf;
        end
    end

    assign valid        = valid_reg;
    assign sorted_value = value_reg;
    assign run_end      = run_end_reg;
    assign overflowed   = ovf_reg;

endmodule

>>> hdl/bsb_seq.sv
// Sequencer: collects items, runs the bubble passes and reads out the set.
`timescale 1ns / 1ps
`include "bubble_sort_buffer_macros.svh"
module bsb_seq
    import bsb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       final_item,
    output logic                       busy,
    output ctrl_t                      ctrl,
    output logic [$clog2(DEPTH)-1:0]   waddr,
    output logic [$clog2(DEPTH)-1:0]   raddr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          drop_reg;
    logic          drop_next;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] k_next;
    logic [AW-1:0] last_reg;
    logic [AW-1:0] last_next;
    logic          accept;
    logic          room;
    logic [AW-1:0] cnt_m1;
    logic          out_last;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign room     = (count_reg < CW'(DEPTH));
    assign cnt_m1   = AW'(count_reg - CW'(1));
    assign out_last = (k_reg == cnt_m1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && final_item)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = (count_reg >= CW'(2)) ? S_FIRST : S_OSTART;
            end
            S_FIRST:
            begin
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (k_reg == last_reg)
                    state_next = S_TAIL;
            end
            S_TAIL:
            begin
                state_next = (last_reg == AW'(1)) ? S_OSTART : S_FIRST;
            end
            S_OSTART:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_last)
                    state_next = S_IDLE;
            end
        endcase
    end

    // Outputs to the datapath and memory addresses.
    always_comb
    begin
        ctrl                = '0;
        ctrl.wsel           = WSEL_IN;
        ctrl.out_ovf        = drop_reg;
        waddr               = '0;
        raddr               = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.mem_we = accept && room;
                waddr       = count_reg[AW-1:0];
            end
            S_PREP:
            begin
                raddr = '0;
            end
            S_FIRST:
            begin
                ctrl.carry_load_mem = 1'b1;
                raddr               = AW'(1);
            end
            S_SWEEP:
            begin
                ctrl.mem_we        = 1'b1;
                ctrl.wsel          = WSEL_LO;
                ctrl.carry_take_hi = 1'b1;
                waddr              = k_reg - AW'(1);
                raddr              = (k_reg == last_reg) ? '0 : k_reg + AW'(1);
            end
            S_TAIL:
            begin
                ctrl.mem_we = 1'b1;
                ctrl.wsel   = WSEL_CARRY;
                waddr       = last_reg;
                raddr       = '0;
            end
            S_OSTART:
            begin
                raddr = '0;
            end
            S_OUT:
            begin
                ctrl.out_fire = 1'b1;
                ctrl.out_last = out_last;
                raddr         = out_last ? '0 : k_reg + AW'(1);
            end
        endcase
    end

    // Counter and index updates.
    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                        count_next = count_reg + CW'(1);
                    else
                        drop_next = 1'b1;
                end
            end
            S_PREP:
            begin
                last_next = cnt_m1;
            end
            S_FIRST:
            begin
                k_next = AW'(1);
            end
            S_SWEEP:
            begin
                if (k_reg != last_reg)
                    k_next = k_reg + AW'(1);
            end
            S_TAIL:
            begin
                last_next = last_reg - AW'(1);
            end
            S_OSTART:
            begin
                k_next = '0;
            end
            S_OUT:
            begin
                k_next = k_reg + AW'(1);
                if (out_last)
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            k_reg     <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end

    // A dropped item can only have come while the buffer was full.
    `BSB_ASSERT(a_drop_full, !drop_reg || (count_reg == CW'(DEPTH)))
    // The last result of a set returns the sequencer to an empty idle state.
    `BSB_ASSERT_NEXT(a_out_clear, ctrl.out_fire && ctrl.out_last, (state_reg == S_IDLE) && (count_reg == '0))
    // A sweep index stays inside the current pass.
    `BSB_ASSERT(a_sweep_range, (state_reg != S_SWEEP) || ((k_reg != '0) && (k_reg <= last_reg)))
    // A pass tail never writes the first entry.
    `BSB_ASSERT(a_tail_nonzero, (state_reg != S_TAIL) || (last_reg != '0))

endmodule

>>> hdl/bubble_sort_buffer.sv
// Top level of the bubble sort buffer: collects a set, sorts it and emits it in order.
// A non-final item is taken without raising busy, so the next item may follow at once.
// For a set of n stored values the sort runs as bubble passes, paced by the
// single compare-and-swap unit and the one-write, one-read buffer memory.
// Results follow as n single-cycle strobes, registered in S_OUT after S_OSTART; busy falls
// as the last one shows. Results cannot be stalled. Reset empties the set and drop flag.
`timescale 1ns / 1ps
module bubble_sort_buffer
    import bsb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] element,
    input  logic                     final_item,
    output logic                     valid,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     run_end,
    output logic                     overflowed
);

    localparam int AW = $clog2(DEPTH);

    ctrl_t         ctrl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    // Sequencer.
    bsb_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .final_item (final_item),
        .busy       (busy),
        .ctrl       (ctrl),
        .waddr      (waddr),
        .raddr      (raddr)
    );

    // Buffer and compare datapath.
    bsb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .waddr        (waddr),
        .raddr        (raddr),
        .element      (element),
        .valid        (valid),
        .sorted_value (sorted_value),
        .run_end      (run_end),
        .overflowed   (overflowed)
    );

endmodule
